### src/meeq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package meeq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ENTRY_WIDTH = 64;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef logic [ENTRY_WIDTH-1:0] entry_t;

	typedef enum logic [1:0] {
		MODE_ENQUEUE = 2'd0,
		MODE_READ    = 2'd1,
		MODE_PIN     = 2'd2,
		MODE_CLEAR   = 2'd3
	} mode_t;

	typedef enum logic {
		STATUS_OK        = 1'b0,
		STATUS_BAD_POS   = 1'b1
	} status_t;

	// per-cell update controls, resolved in priority: load over shift over pin
	typedef struct packed {
		logic load_en;
		logic shift_en;
		logic pin_en;
	} cell_ctrl_t;

endpackage : meeq_pkg

`default_nettype wire

### src/marked_entry_eviction_queue_top.sv
// A word taken with start high gives its result with done high
//   in the next cycle.
// Throughput: one word per cycle; busy stays low, and the queue cells update together.
// Reset: arst_n low clears the fill count and done; cell contents stay undefined.
// The receiver cannot stall: every result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module marked_entry_eviction_queue_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  mode,
	input  wire  [3:0]  position,
	input  wire  [63:0] entry_data,
	input  wire         pin_flag,
	output logic        done,
	output logic        evicted,
	output logic [3:0]  evicted_position,
	output logic [63:0] read_entry,
	output logic        read_pinned,
	output logic        status,
	output logic [4:0]  fill_count
);
	import meeq_pkg::*;

	// Storage is a row of cells, position 0 holding the oldest word. Each cell
	// passes a flag to its right neighbor that says the first unpinned entry has
	// been seen at or before it; on an eviction every cell from the victim onward
	// takes its right neighbor's contents, so the gap closes on the edge that writes the new word.

	logic [CNT_W-1:0] count_q;

	entry_t           cell_data  [QUEUE_DEPTH];
	logic             cell_pin   [QUEUE_DEPTH];
	logic             cell_found [QUEUE_DEPTH+1];
	cell_ctrl_t       cell_ctrl  [QUEUE_DEPTH];

	mode_t            op;
	logic             go;
	logic             full;
	logic             pos_ok;
	logic             evict;
	logic             all_pinned;
	logic [IDX_W-1:0] pos_idx;
	logic [IDX_W-1:0] victim;
	logic [CNT_W-1:0] count_d;
	entry_t           wr_data;

	logic             done_q;
	logic             evicted_q;
	logic [IDX_W-1:0] evpos_q;
	entry_t           rd_data_q;
	logic             rd_pin_q;
	logic             status_q;
	logic [CNT_W-1:0] fill_q;

	assign op         = mode_t'(mode);
	assign go         = start & ~busy;
	assign busy       = 1'b0;
	assign pos_idx    = position[IDX_W-1:0];
	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign pos_ok     = ({1'b0, pos_idx} < count_q);
	assign evict      = go & (op == MODE_ENQUEUE) & full;
	assign all_pinned = ~cell_found[QUEUE_DEPTH];
	assign wr_data    = entry_data[ENTRY_WIDTH-1:0];
	assign cell_found[0] = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			entry_t nxt_data;
			logic   nxt_pin;
			logic   at_tail;

			// last cell has no right neighbor; it always loads on an eviction
			if (gi == QUEUE_DEPTH - 1) begin : g_last
				assign nxt_data = '0;
				assign nxt_pin  = 1'b0;
			end else begin : g_mid
				assign nxt_data = cell_data[gi+1];
				assign nxt_pin  = cell_pin[gi+1];
			end

			assign at_tail = (count_q == CNT_W'(gi));

			always_comb begin
				cell_ctrl[gi].load_en  = go & (op == MODE_ENQUEUE) &
					((~full & at_tail) | (full & (gi == QUEUE_DEPTH - 1)));
				cell_ctrl[gi].shift_en = evict & (cell_found[gi+1] | all_pinned);
				cell_ctrl[gi].pin_en   = go & (op == MODE_PIN) & pos_ok &
					(pos_idx == IDX_W'(gi));
			end

			meeq_cell u_cell (
				.clk       (clk),
				.ctrl      (cell_ctrl[gi]),
				.new_data  (wr_data),
				.new_pin   (pin_flag),
				.nxt_data  (nxt_data),
				.nxt_pin   (nxt_pin),
				.found_in  (cell_found[gi]),
				.data      (cell_data[gi]),
				.pin       (cell_pin[gi]),
				.found_out (cell_found[gi+1])
			);
		end
	endgenerate

	// Victim is the one cell where the flag rises; none rising means all pinned,
	// and the head goes.
	always_comb begin
		victim = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (cell_found[i+1] & ~cell_found[i])
				victim = victim | IDX_W'(i);
		end
	end

	// Fill count after the operation: eviction and append cancel when full.
	always_comb begin
		count_d = count_q;
		case (op)
			MODE_ENQUEUE: begin
				if (!full)
					count_d = count_q + CNT_W'(1);
			end
			MODE_CLEAR:   count_d = '0;
			default:      count_d = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= go;
			if (go)
				count_q <= count_d;
		end
	end

	// Result word, held in registers with no reset; done qualifies them.
	always_ff @(posedge clk) begin
		if (go) begin
			evicted_q <= evict;
			evpos_q   <= evict ? victim : '0;
			rd_data_q <= '0;
			rd_pin_q  <= 1'b0;
			status_q  <= STATUS_OK;
			fill_q    <= count_d;
			case (op)
				MODE_READ: begin
					if (pos_ok) begin
						rd_data_q <= cell_data[pos_idx];
						rd_pin_q  <= cell_pin[pos_idx];
					end else begin
						status_q  <= STATUS_BAD_POS;
					end
				end
				MODE_PIN: begin
					if (!pos_ok)
						status_q <= STATUS_BAD_POS;
				end
				default: begin
				end
			endcase
		end
	end

	assign done             = done_q;
	assign evicted          = evicted_q;
	assign evicted_position = 4'(evpos_q);
	assign read_entry       = 64'(rd_data_q);
	assign read_pinned      = rd_pin_q;
	assign status           = status_q;
	assign fill_count       = 5'(fill_q);

	// Check that each accepted word raises done in the next cycle.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> done)
		else $error("missing result strobe");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("fill count beyond depth");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && evicted) |-> (fill_count == 5'(QUEUE_DEPTH) && status == STATUS_OK))
		else $error("eviction without full queue");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (read_entry == '0 && !read_pinned && !evicted))
		else $error("error result carries data");

endmodule : marked_entry_eviction_queue_top

`default_nettype wire

### src/meeq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module meeq_cell (
	input  wire                  clk,
	input  meeq_pkg::cell_ctrl_t ctrl,
	input  meeq_pkg::entry_t     new_data,
	input  wire                  new_pin,
	input  meeq_pkg::entry_t     nxt_data,
	input  wire                  nxt_pin,
	input  wire                  found_in,
	output meeq_pkg::entry_t     data,
	output logic                 pin,
	output logic                 found_out
);
	import meeq_pkg::*;

	entry_t data_q;
	logic   pin_q;

	// load new word, else take the right neighbor, else rewrite the pin
	always_ff @(posedge clk) begin
		if (ctrl.load_en) begin
			data_q <= new_data;
			pin_q  <= new_pin;
		end else if (ctrl.shift_en) begin
			data_q <= nxt_data;
			pin_q  <= nxt_pin;
		end else if (ctrl.pin_en) begin
			pin_q  <= new_pin;
		end
	end

	// ripple the "first unpinned seen" flag toward the tail
	assign found_out = found_in | ~pin_q;
	assign data      = data_q;
	assign pin       = pin_q;

endmodule : meeq_cell

`default_nettype wire

### dv/meeq_tb_pkg.sv
`timescale 1ns / 1ps

package meeq_tb_pkg;

	import meeq_pkg::*;

	typedef struct {
		logic                 evicted;
		logic [IDX_W-1:0]     evicted_position;
		entry_t               read_entry;
		logic                 read_pinned;
		logic                 status;
		logic [CNT_W-1:0]     fill_count;
	} queue_result_t;

	class queue_scoreboard;
		entry_t        entries[QUEUE_DEPTH];
		logic          pins[QUEUE_DEPTH];
		int            held;
		queue_result_t expected_q[$];
		int            failures;
		int            words;
		int            evictions;
		int            head_evictions;
		int            bad_positions;

		function new();
			held = 0;
			failures = 0;
			words = 0;
			evictions = 0;
			head_evictions = 0;
			bad_positions = 0;
		endfunction

		// apply one accepted word to the queue image and queue its result
		function void note_word(mode_t m, logic [IDX_W-1:0] pos, entry_t data, logic pin);
			queue_result_t r;
			int            victim;
			bit            found;
			r.evicted = 1'b0;
			r.evicted_position = '0;
			r.read_entry = '0;
			r.read_pinned = 1'b0;
			r.status = STATUS_OK;
			words++;
			case (m)
				MODE_ENQUEUE: begin
					if (held == QUEUE_DEPTH) begin
						victim = 0;
						found = 1'b0;
						for (int i = 0; i < held; i++) begin
							if (!found && !pins[i]) begin
								victim = i;
								found = 1'b1;
							end
						end
						if (!found)
							head_evictions++;
						for (int i = victim; i + 1 < held; i++) begin
							entries[i] = entries[i+1];
							pins[i] = pins[i+1];
						end
						held--;
						evictions++;
						r.evicted = 1'b1;
						r.evicted_position = victim[IDX_W-1:0];
					end
					entries[held] = data;
					pins[held] = pin;
					held++;
				end
				MODE_READ: begin
					if (pos < held) begin
						r.read_entry = entries[pos];
						r.read_pinned = pins[pos];
					end else begin
						r.status = STATUS_BAD_POS;
						bad_positions++;
					end
				end
				MODE_PIN: begin
					if (pos < held) begin
						pins[pos] = pin;
					end else begin
						r.status = STATUS_BAD_POS;
						bad_positions++;
					end
				end
				default: begin
					held = 0;
				end
			endcase
			r.fill_count = held[CNT_W-1:0];
			expected_q.push_back(r);
		endfunction

		function void check_result(queue_result_t got);
			queue_result_t want;
			if (expected_q.size() == 0) begin
				$error("result with no word outstanding");
				failures++;
				return;
			end
			want = expected_q.pop_front();
			if (got.evicted !== want.evicted) begin
				$error("evicted: expected %0h, got %0h", want.evicted, got.evicted);
				failures++;
			end
			if (got.evicted_position !== want.evicted_position) begin
				$error("evicted_position: expected %0h, got %0h",
					want.evicted_position, got.evicted_position);
				failures++;
			end
			if (got.read_entry !== want.read_entry) begin
				$error("read_entry: expected %0h, got %0h", want.read_entry, got.read_entry);
				failures++;
			end
			if (got.read_pinned !== want.read_pinned) begin
				$error("read_pinned: expected %0h, got %0h", want.read_pinned, got.read_pinned);
				failures++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0h, got %0h", want.status, got.status);
				failures++;
			end
			if (got.fill_count !== want.fill_count) begin
				$error("fill_count: expected %0h, got %0h", want.fill_count, got.fill_count);
				failures++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

endpackage : meeq_tb_pkg

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import meeq_pkg::*;
	import meeq_tb_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_WORDS = 750;
	localparam int NUM_PHASES   = 4;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  mode;
	logic [3:0]  position;
	logic [63:0] entry_data;
	logic        pin_flag;
	logic        done;
	logic        evicted;
	logic [3:0]  evicted_position;
	logic [63:0] read_entry;
	logic        read_pinned;
	logic        status;
	logic [4:0]  fill_count;

	queue_scoreboard sb;
	int              idle_pct;
	int              pin_pct;
	int              cycle_count;

	// sender idle share per phase; the receiver cannot stall, so the
	// "receiver only" phase runs with the sender at full rate
	int phase_idle[NUM_PHASES] = '{0, 54, 0, 17};

	marked_entry_eviction_queue_top DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.mode             (mode),
		.position         (position),
		.entry_data       (entry_data),
		.pin_flag         (pin_flag),
		.done             (done),
		.evicted          (evicted),
		.evicted_position (evicted_position),
		.read_entry       (read_entry),
		.read_pinned      (read_pinned),
		.status           (status),
		.fill_count       (fill_count)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// hard stop in case a handshake never completes
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// every done cycle carries one result; sample at the edge that ends it
	always @(posedge clk) begin
		queue_result_t got;
		if (arst_n && done === 1'b1) begin
			got.evicted = evicted;
			got.evicted_position = evicted_position;
			got.read_entry = read_entry;
			got.read_pinned = read_pinned;
			got.status = status;
			got.fill_count = fill_count;
			sb.check_result(got);
		end
	end

	function automatic entry_t rand_entry();
		return {$urandom, $urandom};
	endfunction

	// present one word, idling first at the phase's rate; hold it until taken
	task automatic send_word(input mode_t m, input logic [3:0] pos, input entry_t data,
			input logic pin);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			// drop start and scramble the fields so a missed start shows up
			start = 1'b0;
			mode = 2'($urandom);
			position = 4'($urandom);
			entry_data = rand_entry();
			pin_flag = 1'($urandom);
			@(negedge clk);
		end
		start = 1'b1;
		mode = m;
		position = pos;
		entry_data = data;
		pin_flag = pin;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.note_word(m, pos, data, pin);
	endtask

	// walk the empty, filling, full and all-pinned corners by hand
	task automatic run_directed();
		entry_t pattern;
		send_word(MODE_READ, 4'd0, '0, 1'b0);          // read on empty queue
		send_word(MODE_PIN, 4'd15, '1, 1'b1);          // pin on empty queue
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			case (i % 4)
				0: pattern = '0;
				1: pattern = '1;
				2: pattern = {32{2'b10}};
				default: pattern = {32{2'b01}};
			endcase
			// one unpinned slot in the middle to be the first victim
			send_word(MODE_ENQUEUE, 4'(i), pattern, (i == 5) ? 1'b0 : 1'b1);
		end
		send_word(MODE_ENQUEUE, 4'd0, '1, 1'b1);       // full: evict the unpinned one
		send_word(MODE_ENQUEUE, 4'd15, '0, 1'b1);      // full and all pinned: evict head
		send_word(MODE_READ, 4'd15, '0, 1'b0);
		send_word(MODE_READ, 4'd0, '0, 1'b0);
		send_word(MODE_PIN, 4'd3, '0, 1'b0);
		send_word(MODE_CLEAR, 4'd9, '1, 1'b1);
		send_word(MODE_READ, 4'd0, '0, 1'b0);          // read right after clear
	endtask

	// random enqueues, reads, pins and clears with random content; reads and pins mostly in range, a few bad positions
	task automatic run_random(input int count);
		int    roll;
		mode_t m;
		logic [3:0] pos;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < 48)
				m = MODE_ENQUEUE;
			else if (roll < 73)
				m = MODE_READ;
			else if (roll < 97)
				m = MODE_PIN;
			else
				m = MODE_CLEAR;
			if ((m == MODE_READ || m == MODE_PIN) && sb.held > 0
					&& $urandom_range(99) < 85)
				pos = 4'($urandom_range(sb.held - 1));
			else
				pos = 4'($urandom);
			send_word(m, pos, rand_entry(),
				($urandom_range(99) < pin_pct) ? 1'b1 : 1'b0);
			// pick a new pin density per fill so all-pinned queues occur too
			if (m == MODE_CLEAR) begin
				case ($urandom_range(3))
					0: pin_pct = 10;
					1: pin_pct = 50;
					2: pin_pct = 90;
					default: pin_pct = 100;
				endcase
			end
		end
	endtask

	initial begin
		sb = new();
		cycle_count = 0;
		idle_pct = 0;
		pin_pct = 50;
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_ENQUEUE;
		position = '0;
		entry_data = '0;
		pin_flag = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		for (int p = 0; p < NUM_PHASES; p++) begin
			idle_pct = phase_idle[p];
			run_random(RANDOM_WORDS / NUM_PHASES);
		end

		@(negedge clk);
		start = 1'b0;
		// drain outstanding results, then give a stray one time to show up
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Ran %0d words: %0d evictions, %0d of them with every entry pinned,",
			sb.words, sb.evictions, sb.head_evictions);
		$display("%0d out-of-range positions, %0d field mismatches.",
			sb.bad_positions, sb.failures);
		if (sb.failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### sim.f
src/meeq_pkg.sv
src/meeq_cell.sv
src/marked_entry_eviction_queue_top.sv
dv/meeq_tb_pkg.sv
dv/tb_top.sv
